FILE: hdl/shlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlt_pkg
// Shared types and constants of the sample history block.
// ----------------------------------------------------------------------------
package shlt_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned TS_W   = 64;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned BITS_W = 64;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned SEQ_W  = 64;
  localparam int unsigned CNT_W  = 9;

  // Key compare width, one bit above the key so a count of 256 fits
  localparam int unsigned KLIM_W = KEY_W + 1;

  localparam int unsigned S_TDATA_W  = 152;
  localparam int unsigned M_USED_W   = 274;
  localparam int unsigned M_TDATA_W  = 280;

  localparam logic [SEQ_W-1:0] SEQ_MAX      = '1;
  localparam logic [10:0]      EXP_ALL_ONES = 11'h7FF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD    = 3'd0,
    FUNC_READ_LAST = 3'd1,
    FUNC_READ_HIST = 3'd2,
    FUNC_SET_FAV   = 3'd3,
    FUNC_CLEAR     = 3'd4
  } func_e;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   tstamp;
    logic [KEY_W-1:0]  key;
    logic [BITS_W-1:0] bits;
  } ring_entry_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   tstamp;
    logic [BITS_W-1:0] bits;
  } last_entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } ring_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic fav_wr;
    logic fav_val;
    logic clr;
  } tab_ctl_t;

  typedef struct packed {
    logic              acc;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   tstamp;
    logic [KEY_W-1:0]  key;
    logic [BITS_W-1:0] bits;
    logic              mark;
    logic [CNT_W-1:0]  stored;
    logic [SEQ_W-1:0]  total;
  } result_t;

endpackage

FILE: hdl/sample_history_with_latest_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_history_with_latest_table_top
// Keyed sample store: history ring plus per-key latest table and favorites.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | tdata (low bit first)                          | tuser
//  ---------+-----+------------------------------------------------+-----------
//  s_axis   | in  | time_stamp, key, sample_bits, position, mark   | func
//  m_axis   | out | out_sequence, out_time, out_key, out_bits,     | accepted
//           |     | out_mark, stored_count, total_count            |
//
//  Flow: no new transfer is taken while an item sits in the execute stage.
//  The accept edge issues the ring and table reads; the execute stage then
//  has the read data, writes back and loads the result register when it fires.
//  Reset: no clearing pass; only valid bits, favorites, pointers and counts clear.
//  Stalls: the result register holds while m_axis_tready is low; one more
//  item may sit in the execute stage, after which s_axis_tready drops.
//
module sample_history_with_latest_table_top import shlt_pkg::*; #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned KEY_COUNT  = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // time_stamp[63:0], key[71:64], sample_bits[135:72], position[143:136],
  // mark[144], zero fill[151:145]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // func[2:0]
  input  logic [FUNC_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_sequence[63:0], out_time[127:64], out_key[135:128], out_bits[199:136],
  // out_mark[200], stored_count[209:201], total_count[273:210], zero[279:274]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // accepted[0]
  output logic                 m_axis_tuser
);

  localparam logic [KLIM_W-1:0] KEY_LIMIT = KLIM_W'(KEY_COUNT);

  // input fields
  logic [TS_W-1:0]   in_ts;
  logic [KEY_W-1:0]  in_key;
  logic [BITS_W-1:0] in_bits;
  logic [POS_W-1:0]  in_pos;
  logic              in_mark;
  logic              in_acc;

  assign in_ts   = s_axis_tdata[63:0];
  assign in_key  = s_axis_tdata[71:64];
  assign in_bits = s_axis_tdata[135:72];
  assign in_pos  = s_axis_tdata[143:136];
  assign in_mark = s_axis_tdata[144];

  // execute stage
  logic              x_valid_q, x_valid_d;
  func_e             x_func_q;
  logic [TS_W-1:0]   x_ts_q;
  logic [KEY_W-1:0]  x_key_q;
  logic [BITS_W-1:0] x_bits_q;
  logic              x_mark_q;
  logic              x_fire;
  logic              x_key_ok;
  logic              x_finite;
  logic              rec_ok;

  // sample counter; sequence number and accepted total always move together
  logic [SEQ_W-1:0]  cnt_q, cnt_d;

  // result register
  logic              o_valid_q, o_valid_d;
  result_t           o_q, res;

  ring_ctl_t         ring_ctl;
  tab_ctl_t          tab_ctl;
  ring_entry_t       ring_wr, ring_rd;
  last_entry_t       tab_wr, tab_rd;
  logic              ring_hit;
  logic [CNT_W-1:0]  ring_fill;
  logic              tab_valid, tab_fav, ring_fav;

  // reads go out at accept only when the execute stage is empty, so the
  // read data stays put and never overlaps a write-back
  assign s_axis_tready = !x_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign x_fire        = x_valid_q && (!o_valid_q || m_axis_tready);
  assign x_key_ok      = ({1'b0, x_key_q} < KEY_LIMIT);
  assign x_finite      = (x_bits_q[62:52] != EXP_ALL_ONES);

  assign ring_wr = '{seq: cnt_q, tstamp: x_ts_q, key: x_key_q, bits: x_bits_q};
  assign tab_wr  = '{seq: cnt_q, tstamp: x_ts_q, bits: x_bits_q};

  always_comb begin
    res      = '0;
    rec_ok   = 1'b0;
    ring_ctl = '0;
    tab_ctl  = '0;
    ring_ctl.rd_en = in_acc;
    tab_ctl.rd_en  = in_acc;

    case (x_func_q)
      FUNC_RECORD: begin
        rec_ok = x_key_ok && x_finite;
        if (rec_ok) begin
          res.acc    = 1'b1;
          res.seq    = cnt_q;
          res.tstamp = x_ts_q;
          res.key    = x_key_q;
          res.bits   = x_bits_q;
        end
        res.mark = tab_fav;
      end
      FUNC_READ_LAST: begin
        if (tab_valid) begin
          res.acc    = 1'b1;
          res.seq    = tab_rd.seq;
          res.tstamp = tab_rd.tstamp;
          res.key    = x_key_q;
          res.bits   = tab_rd.bits;
        end
        res.mark = tab_fav;
      end
      FUNC_READ_HIST: begin
        if (ring_hit) begin
          res.acc    = 1'b1;
          res.seq    = ring_rd.seq;
          res.tstamp = ring_rd.tstamp;
          res.key    = ring_rd.key;
          res.bits   = ring_rd.bits;
          res.mark   = ring_fav;
        end
      end
      FUNC_SET_FAV: begin
        if (x_key_ok) begin
          res.acc         = 1'b1;
          res.mark        = x_mark_q;
          tab_ctl.fav_wr  = x_fire;
          tab_ctl.fav_val = x_mark_q;
        end
      end
      FUNC_CLEAR: begin
        res.acc      = 1'b1;
        ring_ctl.clr = x_fire;
        tab_ctl.clr  = x_fire;
      end
      default: begin
      end
    endcase

    ring_ctl.wr_en = x_fire && rec_ok;
    tab_ctl.wr_en  = x_fire && rec_ok;

    cnt_d = cnt_q;
    if (ring_ctl.clr) begin
      cnt_d = '0;
    end else if (ring_ctl.wr_en && (cnt_q != SEQ_MAX)) begin
      cnt_d = cnt_q + SEQ_W'(1);
    end

    // counts as they stand after this item
    res.stored = ring_fill;
    res.total  = cnt_d;
  end

  always_comb begin
    x_valid_d = x_valid_q;
    if (in_acc) begin
      x_valid_d = 1'b1;
    end else if (x_fire) begin
      x_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (x_fire) begin
      o_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      x_valid_q <= x_valid_d;
      o_valid_q <= o_valid_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_func_q <= func_e'(s_axis_tuser);
      x_ts_q   <= in_ts;
      x_key_q  <= in_key;
      x_bits_q <= in_bits;
      x_mark_q <= in_mark;
    end
    if (x_fire) begin
      o_q <= res;
    end
  end

  shlt_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ring_ctl),
    .rd_pos_i   (in_pos),
    .wr_entry_i (ring_wr),
    .rd_entry_o (ring_rd),
    .rd_hit_o   (ring_hit),
    .fill_o     (ring_fill)
  );

  shlt_last_tab #(
    .KEY_COUNT (KEY_COUNT)
  ) u_last_tab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (tab_ctl),
    .rd_key_i   (in_key),
    .x_key_i    (x_key_q),
    .ring_key_i (ring_rd.key),
    .wr_entry_i (tab_wr),
    .rd_entry_o (tab_rd),
    .valid_o    (tab_valid),
    .fav_o      (tab_fav),
    .ring_fav_o (ring_fav)
  );

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_q.acc;
  assign m_axis_tdata  = {{(M_TDATA_W - M_USED_W){1'b0}}, o_q.total, o_q.stored, o_q.mark,
                          o_q.bits, o_q.key, o_q.tstamp, o_q.seq};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // a clear leaves the sample counter at zero
  a_clear_zeroes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_fire && (x_func_q == FUNC_CLEAR)) |=> (cnt_q == '0))
    else $error("sample counter not zero after clear");

  // an accepted record below saturation advances the counter by one
  a_record_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_fire && rec_ok && (cnt_q != SEQ_MAX)) |=> (cnt_q == $past(cnt_q) + SEQ_W'(1)))
    else $error("sample counter did not advance on record");

  // a stalled execute item keeps its operation and key until it completes
  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (x_valid_q && !x_fire) |=> (x_valid_q && $stable(x_func_q) && $stable(x_key_q)))
    else $error("execute stage item lost while stalled");

  // memory reads never replace data that the execute stage still needs
  a_read_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ring_ctl.rd_en || tab_ctl.rd_en) |-> !x_valid_q)
    else $error("memory read issued while execute stage busy");

endmodule

FILE: hdl/shlt_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlt_ring
// Overwrite-oldest history ring: entry memory, write head and fill count.
// ----------------------------------------------------------------------------
module shlt_ring import shlt_pkg::*; #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_ctl_t         ctl_i,
  input  logic [POS_W-1:0]  rd_pos_i,
  input  ring_entry_t       wr_entry_i,
  output ring_entry_t       rd_entry_o,
  output logic              rd_hit_o,
  output logic [CNT_W-1:0]  fill_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = ((FW > POS_W) ? FW : POS_W) + 1;
  localparam logic [AW-1:0] HEAD_LAST = AW'(RING_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);
  localparam logic [SW-1:0] DEPTH_S   = SW'(RING_DEPTH);

  ring_entry_t       mem_q [RING_DEPTH];
  ring_entry_t       rd_q;
  logic [AW-1:0]     head_q, head_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic              hit_q;
  logic [SW-1:0]     oldest_raw, oldest, idx_raw, idx;
  logic [AW-1:0]     rd_addr;

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (ctl_i.clr) begin
      head_d = '0;
      fill_d = '0;
    end else if (ctl_i.wr_en) begin
      head_d = (head_q == HEAD_LAST) ? '0 : head_q + AW'(1);
      if (fill_q != FILL_FULL) begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  // oldest = (head - fill) mod depth, then + pos mod depth; a hit keeps both below 2*depth
  always_comb begin
    oldest_raw = SW'(head_q) + DEPTH_S - SW'(fill_q);
    oldest     = (oldest_raw >= DEPTH_S) ? oldest_raw - DEPTH_S : oldest_raw;
    idx_raw    = oldest + SW'(rd_pos_i);
    idx        = (idx_raw >= DEPTH_S) ? idx_raw - DEPTH_S : idx_raw;
    rd_addr    = idx[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (ctl_i.rd_en) begin
        hit_q <= (SW'(rd_pos_i) < SW'(fill_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[head_q] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign rd_entry_o = rd_q;
  assign rd_hit_o   = hit_q;
  assign fill_o     = CNT_W'(fill_d);

endmodule

FILE: hdl/shlt_last_tab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shlt_last_tab
// Per-key latest sample memory with valid bits and favorite flags.
// ----------------------------------------------------------------------------
module shlt_last_tab import shlt_pkg::*; #(
  parameter int unsigned KEY_COUNT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tab_ctl_t          ctl_i,
  input  logic [KEY_W-1:0]  rd_key_i,
  input  logic [KEY_W-1:0]  x_key_i,
  input  logic [KEY_W-1:0]  ring_key_i,
  input  last_entry_t       wr_entry_i,
  output last_entry_t       rd_entry_o,
  output logic              valid_o,
  output logic              fav_o,
  output logic              ring_fav_o
);

  localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [KLIM_W-1:0] KEY_LIMIT = KLIM_W'(KEY_COUNT);

  last_entry_t          mem_q [KEY_COUNT];
  last_entry_t          rd_q;
  logic [KEY_COUNT-1:0] valid_q;
  logic [KEY_COUNT-1:0] fav_q;
  logic [KW-1:0]        rd_idx, x_idx, ring_idx;
  logic                 x_ok, ring_ok;

  assign rd_idx   = rd_key_i[KW-1:0];
  assign x_idx    = x_key_i[KW-1:0];
  assign ring_idx = ring_key_i[KW-1:0];
  assign x_ok     = ({1'b0, x_key_i} < KEY_LIMIT);
  assign ring_ok  = ({1'b0, ring_key_i} < KEY_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fav_q   <= '0;
    end else begin
      if (ctl_i.clr) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[x_idx] <= 1'b1;
      end
      if (ctl_i.fav_wr) begin
        fav_q[x_idx] <= ctl_i.fav_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[x_idx] <= wr_entry_i;
    end
    if (ctl_i.rd_en) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  assign rd_entry_o = rd_q;
  assign valid_o    = x_ok && valid_q[x_idx];
  assign fav_o      = x_ok && fav_q[x_idx];
  assign ring_fav_o = ring_ok && fav_q[ring_idx];

endmodule

FILE: tb/sample_history_with_latest_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_history_with_latest_table_top_tb
// Self-checking bench for the keyed sample store. A scoreboard model of the
// history ring, the latest table and the favorite marks predicts one response
// per transfer. A queued driver and a monitor throttle both stream sides, and
// every response is compared field by field.
// ----------------------------------------------------------------------------
module sample_history_with_latest_table_top_tb;
  import shlt_pkg::*;

  localparam int RING_ENTRIES = 256;
  localparam int KEY_TOTAL    = 256;
  localparam int RAND_OPS     = 1550;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIGHT   = 26;
  localparam int IDLE_HEAVY   = 55;

  // Top func code; the codes above FUNC_CLEAR are unused by the block
  localparam logic [FUNC_W-1:0] FUNC_TOP       = '1;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = FUNC_W'(FUNC_CLEAR + 1);

  localparam logic [BITS_W-1:0] MAX_FINITE    = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [BITS_W-1:0] POS_INF       = 64'h7FF0_0000_0000_0000;
  localparam logic [BITS_W-1:0] QUIET_NAN     = 64'hFFF8_0000_0000_0001;
  localparam logic [BITS_W-1:0] NEG_SUBNORMAL = 64'h800F_FFFF_FFFF_FFFF;

  // One pending input item; hold_off makes the driver wait until the store
  // has answered everything already sent
  typedef struct packed {
    logic              hold_off;
    logic [FUNC_W-1:0] func;
    logic [TS_W-1:0]   tstamp;
    logic [KEY_W-1:0]  key;
    logic [BITS_W-1:0] bits;
    logic [POS_W-1:0]  pos;
    logic              mark;
  } sample_op_t;

  logic                 clk_i  = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [FUNC_W-1:0]    s_tuser  = '0;
  logic                 m_ready  = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  sample_op_t op_queue[$];
  result_t    pending_responses[$];
  sample_op_t cur_op;

  int total_ops      = 0;
  int accepted_count = 0;   // input transfers, updated at the edge (NBA)
  int checked_count  = 0;   // responses matched against a prediction (NBA)
  int err_count      = 0;
  int phase_q        = 0;   // 0: sender light idle, 1: sender heavy, 2: no idle
  int gen_fill       = 0;   // ring fill as the stimulus generator sees it

  // Scoreboard copy of the store
  logic [SEQ_W-1:0]  hist_seq  [RING_ENTRIES];
  logic [TS_W-1:0]   hist_time [RING_ENTRIES];
  logic [KEY_W-1:0]  hist_key  [RING_ENTRIES];
  logic [BITS_W-1:0] hist_val  [RING_ENTRIES];
  logic [SEQ_W-1:0]  latest_seq  [KEY_TOTAL];
  logic [TS_W-1:0]   latest_time [KEY_TOTAL];
  logic [BITS_W-1:0] latest_val  [KEY_TOTAL];
  logic              latest_ok   [KEY_TOTAL];
  logic              fav_mark    [KEY_TOTAL];
  logic [KEY_W-1:0]  hist_head;
  logic [CNT_W-1:0]  hist_fill;
  logic [SEQ_W-1:0]  seq_next;
  logic [SEQ_W-1:0]  sample_total;

  always #5 clk_i = ~clk_i;

  sample_history_with_latest_table_top #(
    .RING_DEPTH(RING_ENTRIES),
    .KEY_COUNT (KEY_TOTAL)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h (response %0d)", what, got, want,
             checked_count);
    err_count++;
  endtask

  // Applies one accepted item to the scoreboard store and queues the response
  task automatic compute_response(input sample_op_t op);
    result_t          r;
    logic [KEY_W-1:0] oldest;
    logic [KEY_W-1:0] idx;
    r = '0;
    case (op.func)
      FUNC_RECORD: begin
        // Finite means the exponent field is not all ones
        if (op.bits[62:52] != EXP_ALL_ONES) begin
          r.seq = seq_next;
          if (seq_next != SEQ_MAX) seq_next++;
          if (sample_total != SEQ_MAX) sample_total++;
          latest_seq[op.key]  = r.seq;
          latest_time[op.key] = op.tstamp;
          latest_val[op.key]  = op.bits;
          latest_ok[op.key]   = 1'b1;
          hist_seq[hist_head]  = r.seq;
          hist_time[hist_head] = op.tstamp;
          hist_key[hist_head]  = op.key;
          hist_val[hist_head]  = op.bits;
          hist_head++;                        // ring of 256 wraps with the byte
          if (hist_fill < RING_ENTRIES) hist_fill++;
          r.acc    = 1'b1;
          r.tstamp = op.tstamp;
          r.key    = op.key;
          r.bits   = op.bits;
        end
        r.mark = fav_mark[op.key];
      end
      FUNC_READ_LAST: begin
        if (latest_ok[op.key]) begin
          r.acc    = 1'b1;
          r.seq    = latest_seq[op.key];
          r.tstamp = latest_time[op.key];
          r.key    = op.key;
          r.bits   = latest_val[op.key];
        end
        r.mark = fav_mark[op.key];
      end
      FUNC_READ_HIST: begin
        if (op.pos < hist_fill) begin
          oldest   = hist_head - hist_fill[KEY_W-1:0];
          idx      = oldest + op.pos;
          r.acc    = 1'b1;
          r.seq    = hist_seq[idx];
          r.tstamp = hist_time[idx];
          r.key    = hist_key[idx];
          r.bits   = hist_val[idx];
          r.mark   = fav_mark[hist_key[idx]];
        end
      end
      FUNC_SET_FAV: begin
        fav_mark[op.key] = op.mark;
        r.acc  = 1'b1;
        r.mark = op.mark;
      end
      FUNC_CLEAR: begin
        // Favorites survive a clear; stale ring and table data is never read
        foreach (latest_ok[i]) latest_ok[i] = 1'b0;
        hist_head    = '0;
        hist_fill    = '0;
        seq_next     = '0;
        sample_total = '0;
        r.acc        = 1'b1;
      end
      default: ;
    endcase
    r.stored = hist_fill;
    r.total  = sample_total;
    pending_responses.push_back(r);
  endtask

  // Queues one item and tracks the ring fill so history reads can aim inside
  task automatic push_op(input logic [FUNC_W-1:0] f, input logic [TS_W-1:0] ts,
                         input logic [KEY_W-1:0] k, input logic [BITS_W-1:0] b,
                         input logic [POS_W-1:0] p, input logic m,
                         input logic hold);
    sample_op_t op;
    op = '{hold_off: hold, func: f, tstamp: ts, key: k, bits: b, pos: p, mark: m};
    op_queue.push_back(op);
    if (f == FUNC_RECORD && b[62:52] != EXP_ALL_ONES && gen_fill < RING_ENTRIES)
      gen_fill++;
    if (f == FUNC_CLEAR) gen_fill = 0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued items on s_axis. A presented item is held until
  // its transfer; the next one is loaded at that same edge or after an idle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    logic xfer;
    int   in_flight;
    int   tx_idle;
    if (!rst_ni) begin
      s_tvalid       <= 1'b0;
      accepted_count <= 0;
      phase_q        <= 0;
    end else begin
      xfer = s_tvalid && s_axis_tready;
      if (xfer) begin
        compute_response(cur_op);
        accepted_count <= accepted_count + 1;
      end
      // checked_count lags by at most one response here, so the hold-off
      // errs on the late side
      in_flight = accepted_count + int'(xfer) - checked_count;
      tx_idle   = (phase_q == 0) ? IDLE_LIGHT : (phase_q == 1) ? IDLE_HEAVY : 0;
      if (!s_tvalid || s_axis_tready) begin
        if (op_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle &&
            !(op_queue[0].hold_off && in_flight != 0)) begin
          cur_op   = op_queue.pop_front();
          s_tvalid <= 1'b1;
          // tdata: time_stamp, key, sample_bits, position, mark, zero fill
          s_tdata  <= {7'b0, cur_op.mark, cur_op.pos, cur_op.bits, cur_op.key,
                       cur_op.tstamp};
          s_tuser  <= cur_op.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      phase_q <= (accepted_count >= 2 * total_ops / 3) ? 2 :
                 (accepted_count >= total_ops / 3) ? 1 : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: throttles m_axis_tready and checks each response transfer
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : monitor_blk
    result_t got;
    result_t want;
    int      rx_idle;
    if (!rst_ni) begin
      m_ready       <= 1'b0;
      checked_count <= 0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        got.acc    = m_axis_tuser;
        got.seq    = m_axis_tdata[63:0];
        got.tstamp = m_axis_tdata[127:64];
        got.key    = m_axis_tdata[135:128];
        got.bits   = m_axis_tdata[199:136];
        got.mark   = m_axis_tdata[200];
        got.stored = m_axis_tdata[209:201];
        got.total  = m_axis_tdata[273:210];
        if (pending_responses.size() == 0) begin
          report_mismatch("response with nothing pending", got.seq, '0);
        end else begin
          want = pending_responses.pop_front();
          checked_count <= checked_count + 1;
          if (got.acc !== want.acc)
            report_mismatch("accepted", 64'(got.acc), 64'(want.acc));
          if (got.seq !== want.seq) report_mismatch("out_sequence", got.seq, want.seq);
          if (got.tstamp !== want.tstamp)
            report_mismatch("out_time", got.tstamp, want.tstamp);
          if (got.key !== want.key)
            report_mismatch("out_key", 64'(got.key), 64'(want.key));
          if (got.bits !== want.bits) report_mismatch("out_bits", got.bits, want.bits);
          if (got.mark !== want.mark)
            report_mismatch("out_mark", 64'(got.mark), 64'(want.mark));
          if (got.stored !== want.stored)
            report_mismatch("stored_count", 64'(got.stored), 64'(want.stored));
          if (got.total !== want.total)
            report_mismatch("total_count", got.total, want.total);
        end
      end
      // Receiver idles heavily while the sender is light, then the reverse
      rx_idle = (phase_q == 0) ? IDLE_HEAVY : (phase_q == 1) ? IDLE_LIGHT : 0;
      m_ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of test
  // --------------------------------------------------------------------------
  initial begin
    int                sel;
    logic [FUNC_W-1:0] f;
    logic [TS_W-1:0]   ts;
    logic [KEY_W-1:0]  k;
    logic [BITS_W-1:0] b;
    logic [POS_W-1:0]  p;
    logic              m;
    logic              hold;

    foreach (latest_ok[i]) begin
      latest_ok[i] = 1'b0;
      fav_mark[i]  = 1'b0;
    end
    hist_head    = '0;
    hist_fill    = '0;
    seq_next     = '0;
    sample_total = '0;

    // Directed: empty-store reads, field extremes, rejected values, marks,
    // reads past the count, unused codes and a clear that keeps favorites
    push_op(FUNC_READ_LAST, '0, 8'd0, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd0, 1'b0, 1'b0);
    push_op(FUNC_RECORD, '0, 8'd0, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_RECORD, '1, 8'd255, MAX_FINITE, '1, 1'b1, 1'b0);
    push_op(FUNC_RECORD, 64'd77, 8'd3, POS_INF, '0, 1'b0, 1'b0);
    push_op(FUNC_RECORD, 64'd78, 8'd4, QUIET_NAN, '0, 1'b0, 1'b0);
    push_op(FUNC_RECORD, 64'd79, 8'd5, NEG_SUBNORMAL, '0, 1'b0, 1'b0);
    push_op(FUNC_SET_FAV, '0, 8'd255, '0, '0, 1'b1, 1'b0);
    push_op(FUNC_SET_FAV, '0, 8'd0, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_LAST, '0, 8'd255, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_LAST, '0, 8'd0, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_LAST, '0, 8'd3, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd0, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd1, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd2, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd3, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd255, 1'b0, 1'b0);
    push_op(FUNC_UNUSED_LO, '1, 8'd255, '1, '1, 1'b1, 1'b0);
    push_op(FUNC_TOP, '1, 8'd1, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_CLEAR, '0, '0, '0, '0, 1'b0, 1'b1);
    push_op(FUNC_READ_LAST, '0, 8'd255, '0, '0, 1'b0, 1'b0);
    push_op(FUNC_READ_HIST, '0, '0, '0, 8'd0, 1'b0, 1'b0);
    push_op(FUNC_RECORD, 64'd5, 8'd255, 64'h3FF0_0000_0000_0000, '0, 1'b0, 1'b0);
    push_op(FUNC_SET_FAV, '0, 8'd255, '0, '0, 1'b0, 1'b0);

    // Random: mostly finite records and reads aimed inside the ring; a clear
    // only once the ring is full, so overwrite-oldest gets exercised
    for (int i = 0; i < RAND_OPS; i++) begin
      sel  = $urandom_range(0, 999);
      ts   = {$urandom, $urandom};
      k    = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 15))
                                  : KEY_W'($urandom_range(0, 255));
      b    = {$urandom, $urandom};
      p    = POS_W'($urandom_range(0, 255));
      m    = 1'($urandom_range(0, 1));
      hold = (i == RAND_OPS / 3) || (i == 2 * RAND_OPS / 3) ||
             ($urandom_range(0, 199) == 0);
      if (sel < 450) begin
        f = FUNC_RECORD;
        if ($urandom_range(0, 9) == 0) b[62:52] = EXP_ALL_ONES;
        else if (b[62:52] == EXP_ALL_ONES) b[52] = 1'b0;
      end else if (sel < 650) begin
        f = FUNC_READ_LAST;
      end else if (sel < 880) begin
        f = FUNC_READ_HIST;
        if (gen_fill > 0 && $urandom_range(0, 9) != 0)
          p = POS_W'($urandom_range(0, gen_fill - 1));
      end else if (sel < 960) begin
        f = FUNC_SET_FAV;
      end else if (sel < 980) begin
        // Past-count history reads, or a clear once the ring is full
        f = (gen_fill == RING_ENTRIES && $urandom_range(0, 3) == 0) ? FUNC_CLEAR
                                                                    : FUNC_READ_HIST;
      end else begin
        f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_TOP));
      end
      push_op(f, ts, k, b, p, m, hold);
    end
    total_ops = op_queue.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (accepted_count != total_ops || checked_count != total_ops);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_responses.size() != 0)
      report_mismatch("responses never received", 64'(pending_responses.size()), '0);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
